### design/binomial_term_generator_defines.svh
// Assertion macros used by the binomial term generator controller.
`ifndef BINOMIAL_TERM_GENERATOR_DEFINES_SVH
`define BINOMIAL_TERM_GENERATOR_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BTG_ASSERT_SAME(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |-> (cons)) \
    else $error("assertion failed: %m");

// Checks that the consequent holds in the cycle after the antecedent.
`define BTG_ASSERT_NEXT(lbl, clk_s, rst_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (ante) |=> (cons)) \
    else $error("assertion failed: %m");

`endif

### design/btg_pkg.sv
// Shared constants, state type and command struct of the binomial term generator.
package btg_pkg;

  localparam int MAX_POWER = 31;
  localparam int N_W       = 5;
  localparam int COEF_W    = 16;
  localparam int VAL_W     = 64;
  localparam int PROD_W    = VAL_W + COEF_W;
  localparam int ROW_N     = MAX_POWER + 1;
  // C(n,k) stays below 2^n, so MAX_POWER bits hold every row entry.
  localparam int BINOM_W   = MAX_POWER;

  localparam logic [VAL_W-1:0] POS_LIMIT = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic [VAL_W-1:0] NEG_LIMIT = {1'b1, {(VAL_W-1){1'b0}}};

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_BUILD,
    ST_TERM,
    ST_MUL_A,
    ST_MUL_B,
    ST_EMIT
  } state_t;

  typedef struct packed {
    logic           load;
    logic           build;
    logic           term_init;
    logic           mul_a;
    logic           mul_b;
    logic           emit;
    logic [N_W-1:0] k;
    logic [N_W-1:0] n;
  } cmd_t;

endpackage

### design/btg_ctrl.sv
// Controller state machine that sequences row build, multiplies and term output.
`include "binomial_term_generator_defines.svh"

module btg_ctrl (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [btg_pkg::N_W-1:0] power_n,
  output logic                    busy,
  output btg_pkg::cmd_t           cmd
);
  import btg_pkg::*;

  state_t         state;
  state_t         state_next;
  logic [N_W-1:0] n;
  logic [N_W-1:0] n_next;
  logic [N_W-1:0] k;
  logic [N_W-1:0] k_next;
  logic [N_W-1:0] cnt;
  logic [N_W-1:0] cnt_next;
  logic [N_W-1:0] n_clamp;
  logic [N_W-1:0] ea;

  assign n_clamp = (int'(power_n) > MAX_POWER) ? N_W'(MAX_POWER) : power_n;
  assign ea      = n - k;
  assign busy    = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      n     <= '0;
      k     <= '0;
      cnt   <= '0;
    end else begin
      state <= state_next;
      n     <= n_next;
      k     <= k_next;
      cnt   <= cnt_next;
    end
  end

  always_comb begin
    state_next = state;
    n_next     = n;
    k_next     = k;
    cnt_next   = cnt;
    cmd        = '0;
    cmd.k      = k;
    cmd.n      = n;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          n_next     = n_clamp;
          k_next     = '0;
          cnt_next   = n_clamp;
          state_next = (n_clamp == '0) ? ST_TERM : ST_BUILD;
        end
      end
      ST_BUILD: begin
        cmd.build = 1'b1;
        cnt_next  = cnt - N_W'(1);
        if (cnt == N_W'(1)) begin
          state_next = ST_TERM;
        end
      end
      ST_TERM: begin
        cmd.term_init = 1'b1;
        if (ea != '0) begin
          cnt_next   = ea;
          state_next = ST_MUL_A;
        end else if (k != '0) begin
          cnt_next   = k;
          state_next = ST_MUL_B;
        end else begin
          state_next = ST_EMIT;
        end
      end
      ST_MUL_A: begin
        cmd.mul_a = 1'b1;
        cnt_next  = cnt - N_W'(1);
        if (cnt == N_W'(1)) begin
          if (k != '0) begin
            cnt_next   = k;
            state_next = ST_MUL_B;
          end else begin
            state_next = ST_EMIT;
          end
        end
      end
      ST_MUL_B: begin
        cmd.mul_b = 1'b1;
        cnt_next  = cnt - N_W'(1);
        if (cnt == N_W'(1)) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (k == n) begin
          state_next = ST_IDLE;
        end else begin
          k_next     = k + N_W'(1);
          state_next = ST_TERM;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `BTG_ASSERT_NEXT(a_last_emit_idles, clk, rst, (state == ST_EMIT) && (k == n), state == ST_IDLE)
  `BTG_ASSERT_SAME(a_index_in_range, clk, rst, state != ST_IDLE, k <= n)
  `BTG_ASSERT_NEXT(a_accept_goes_busy, clk, rst, start && !busy, busy)
  `BTG_ASSERT_SAME(a_mul_count_live, clk, rst, (state == ST_MUL_A) || (state == ST_MUL_B),
                   cnt != '0)

endmodule

### design/btg_datapath.sv
// Datapath: Pascal row cells, saturating magnitude multiplier and result register.
module btg_datapath (
  input  logic                              clk,
  input  logic                              rst,
  input  btg_pkg::cmd_t                     cmd,
  input  logic signed [btg_pkg::COEF_W-1:0] coef_a,
  input  logic signed [btg_pkg::COEF_W-1:0] coef_b,
  output logic                              term_valid,
  output logic [btg_pkg::N_W-1:0]           term_index,
  output logic signed [btg_pkg::VAL_W-1:0]  term_value,
  output logic                              overflow,
  output logic                              last_term
);
  import btg_pkg::*;

  logic [BINOM_W-1:0] row [ROW_N];
  logic [COEF_W-1:0]  a_mag;
  logic [COEF_W-1:0]  b_mag;
  logic               a_neg;
  logic               b_neg;
  logic [VAL_W-1:0]   mag;
  logic               big;

  logic [N_W-1:0]     ea;
  logic               neg;
  logic               zero_term;
  logic [VAL_W-1:0]   lim;
  logic [COEF_W-1:0]  fac;
  logic [PROD_W-1:0]  prod;
  logic               over;

  assign ea  = cmd.n - cmd.k;
  assign neg = (a_neg & ea[0]) ^ (b_neg & cmd.k[0]);
  assign lim = neg ? NEG_LIMIT : POS_LIMIT;
  assign zero_term = ((a_mag == '0) && (ea != '0)) || ((b_mag == '0) && (cmd.k != '0));

  assign fac  = cmd.mul_a ? a_mag : b_mag;
  assign prod = PROD_W'(mag) * PROD_W'(fac);
  assign over = big || (prod > PROD_W'(lim));

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      a_neg <= coef_a[COEF_W-1];
      b_neg <= coef_b[COEF_W-1];
      a_mag <= coef_a[COEF_W-1] ? COEF_W'(-coef_a) : COEF_W'(coef_a);
      b_mag <= coef_b[COEF_W-1] ? COEF_W'(-coef_b) : COEF_W'(coef_b);
    end
  end

  // Load sets row 0; each build step turns row i into row i+1; each emitted term shifts the row down.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      row[0] <= BINOM_W'(1);
      for (int j = 1; j < ROW_N; j++) begin
        row[j] <= '0;
      end
    end else if (cmd.build) begin
      for (int j = 1; j < ROW_N; j++) begin
        row[j] <= row[j] + row[j-1];
      end
    end else if (cmd.emit) begin
      for (int j = 0; j < ROW_N - 1; j++) begin
        row[j] <= row[j+1];
      end
      row[ROW_N-1] <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.term_init) begin
      mag <= VAL_W'(row[0]);
      big <= 1'b0;
    end else if (cmd.mul_a || cmd.mul_b) begin
      mag <= over ? lim : prod[VAL_W-1:0];
      big <= over;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      term_valid <= 1'b0;
    end else begin
      term_valid <= cmd.emit;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      term_index <= cmd.k;
      last_term  <= (cmd.k == cmd.n);
      if (zero_term) begin
        term_value <= '0;
        overflow   <= 1'b0;
      end else begin
        term_value <= neg ? $signed(~mag + VAL_W'(1)) : $signed(mag);
        overflow   <= big;
      end
    end
  end

endmodule

### design/binomial_term_generator.sv
// Top level of the binomial term generator: controller plus datapath.
//
//   Channel   Handshake            Payload                                      Dir
//   request   start / busy         coef_a, coef_b, power_n                      in
//   term      term_valid (strobe)  term_index, term_value, overflow, last_term  out
//
// A request beat is taken at a rising edge with start high and busy low.
// A single 64x16 saturating multiplier applies every factor of a term in
// turn. Before that, build steps form Pascal row n in a row of adder cells.
// Each term beat shows on the outputs for exactly one cycle; the receiver
// cannot stall it. rst is synchronous and returns the block to idle.
module binomial_term_generator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic signed [btg_pkg::COEF_W-1:0] coef_a,
  input  logic signed [btg_pkg::COEF_W-1:0] coef_b,
  input  logic [btg_pkg::N_W-1:0]           power_n,
  output logic                              term_valid,
  output logic [btg_pkg::N_W-1:0]           term_index,
  output logic signed [btg_pkg::VAL_W-1:0]  term_value,
  output logic                              overflow,
  output logic                              last_term
);
  import btg_pkg::*;

  // Commands from the controller carry the current term index and power too,
  // so the datapath can work out sign, saturation limit and zero terms.
  cmd_t cmd;

  btg_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .power_n (power_n),
    .busy    (busy),
    .cmd     (cmd)
  );

  // The datapath holds the magnitudes of a and b, the binomial row, and the
  // running term magnitude. Once a product passes the limit of the term's
  // sign, the magnitude sticks at that limit and the overflow flag is set.
  btg_datapath u_datapath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .coef_a     (coef_a),
    .coef_b     (coef_b),
    .term_valid (term_valid),
    .term_index (term_index),
    .term_value (term_value),
    .overflow   (overflow),
    .last_term  (last_term)
  );

endmodule
